// ===== sv/plaintext_byte_tokenizer_top_assert.svh =====
// assertion macros for the plaintext byte tokenizer
`ifndef PLAINTEXT_BYTE_TOKENIZER_TOP_ASSERT_SVH
`define PLAINTEXT_BYTE_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// when a holds, b must hold in the same cycle
`define PBT_ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("tokenizer assertion failed");

// cond must never hold
`define PBT_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("tokenizer assertion failed");

`else

`define PBT_ASSERT_IMPLIES(label, clk, rstn, a, b)
`define PBT_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// ===== sv/pbt_pkg.sv =====
// shared types and constants of the plaintext byte tokenizer
`timescale 1ns / 1ps
`default_nettype none

package pbt_pkg;

    // token buffer geometry
    localparam int MAX_TOKEN_CHARS = 32;
    localparam int LEN_W           = 6;
    localparam int IDX_W           = (MAX_TOKEN_CHARS > 1) ? $clog2(MAX_TOKEN_CHARS) : 1;
    localparam int RAM_AW          = IDX_W + 1;
    localparam int RAM_DEPTH       = 2 ** RAM_AW;

    // field widths
    localparam int POS_W  = 24;
    localparam int NUM_W  = 31;
    localparam int CHAR_W = 7;
    localparam int PROD_W = NUM_W + 4;

    localparam logic [POS_W-1:0] POS_MAX = 24'hFFFFFF;
    localparam logic [NUM_W-1:0] NUM_MAX = 31'h7FFFFFFF;

    // token kinds on the result channel
    localparam logic [1:0] TK_STRING  = 2'd0;
    localparam logic [1:0] TK_NUMBER  = 2'd1;
    localparam logic [1:0] TK_PUNCT   = 2'd2;
    localparam logic [1:0] TK_NEWLINE = 2'd3;

    // pending token codes
    localparam logic [1:0] PK_NONE   = 2'd0;
    localparam logic [1:0] PK_STRING = 2'd1;
    localparam logic [1:0] PK_NUMBER = 2'd2;

    // input actions
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_ASCII_MAX = 8'd127;

    // command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_DROP_PUNCT = 2'd0;
    localparam logic [1:0] REG_FOLD_LOWER = 2'd1;
    localparam logic [1:0] REG_DROP_NUM   = 2'd2;
    localparam logic [1:0] REG_DROP_NL    = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] text_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        token_kind;
        logic [POS_W-1:0]  line_number;
        logic [POS_W-1:0]  column_number;
        logic [NUM_W-1:0]  number_value;
        logic [CHAR_W-1:0] char_code;
        logic              last_of_token;
        logic              overflow_flag;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  column;
        logic [NUM_W-1:0]  number;
        logic [CHAR_W-1:0] char_code;
        logic              ovf;
        logic [LEN_W-1:0]  length;
        logic              bank;
    } cmd_t;

    typedef struct packed {
        logic drop_punctuation;
        logic fold_lowercase;
        logic drop_numbers;
        logic drop_newlines;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic bank;
    } back_status_t;

endpackage

`default_nettype wire

// ===== sv/pbt_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/pbt_fifo.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module pbt_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pbt_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output pbt_pkg::cmd_t pop_data,
    output logic          empty
);
    import pbt_pkg::*;

    cmd_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pbt_front.sv =====
// front end: byte classification, token state and command issue
`timescale 1ns / 1ps
`default_nettype none

module pbt_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pbt_pkg::cfg_t                  cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pbt_pkg::in_item_t              s_data,
    input  logic                           q_full,
    output logic                           q_push,
    output pbt_pkg::cmd_t                  q_data,
    output logic                           ram_we,
    output logic [pbt_pkg::RAM_AW-1:0]     ram_waddr,
    output logic [pbt_pkg::CHAR_W-1:0]     ram_wdata,
    input  pbt_pkg::back_status_t          back_st
);
    import pbt_pkg::*;

    logic [1:0]       pending_kind_reg, pending_kind_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [POS_W-1:0] start_line_reg, start_line_next;
    logic [POS_W-1:0] first_col_reg, first_col_next;
    logic [POS_W-1:0] cur_line_reg, cur_line_next;
    logic [POS_W-1:0] cur_col_reg, cur_col_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             extra_valid_reg, extra_valid_next;
    cmd_t             extra_reg, extra_next;

    logic              accept;
    logic [7:0]        byte_val;
    logic              is_space, is_digit, is_alpha, is_punct, is_upper;
    logic              do_flush, own_valid;
    cmd_t              flush_cmd, own_cmd;
    logic [PROD_W-1:0] prod;
    logic [CHAR_W-1:0] fold_char;

    // hold off while a second command waits, the queue is full, or the next
    // string would land in a bank still being read out
    assign s_ready = !extra_valid_reg && !q_full &&
                     !(busy_reg[wbank_reg] && (pending_kind_reg != PK_STRING));
    assign accept  = s_valid && s_ready;

    // byte classes
    assign byte_val = s_data.text_byte;
    assign is_space = (byte_val == 8'd32) || ((byte_val >= 8'd9) && (byte_val <= 8'd13));
    assign is_digit = (byte_val >= 8'd48) && (byte_val <= 8'd57);
    assign is_upper = (byte_val >= 8'd65) && (byte_val <= 8'd90);
    assign is_alpha = is_upper || ((byte_val >= 8'd97) && (byte_val <= 8'd122));
    assign is_punct = !is_space && !is_digit && !is_alpha;

    assign fold_char = (cfg.fold_lowercase && is_upper) ? byte_val[6:0] + 7'd32
                                                        : byte_val[6:0];

    // command for the pending token
    always_comb begin
        flush_cmd           = '0;
        flush_cmd.kind      = (pending_kind_reg == PK_STRING) ? TK_STRING : TK_NUMBER;
        flush_cmd.line      = start_line_reg;
        flush_cmd.column    = first_col_reg;
        flush_cmd.number    = (pending_kind_reg == PK_NUMBER) ? acc_reg : '0;
        flush_cmd.ovf       = ovf_reg;
        flush_cmd.length    = len_reg;
        flush_cmd.bank      = wbank_reg;
    end

    // command for the byte's own punctuation or newline token
    always_comb begin
        own_cmd           = '0;
        own_cmd.kind      = is_punct ? TK_PUNCT : TK_NEWLINE;
        own_cmd.line      = cur_line_reg;
        own_cmd.column    = cur_col_reg;
        own_cmd.char_code = byte_val[6:0];
        own_valid         = is_punct ? !cfg.drop_punctuation
                                     : ((byte_val == CH_NEWLINE) && !cfg.drop_newlines);
    end

    // token state update
    always_comb begin
        pending_kind_next = pending_kind_reg;
        len_next          = len_reg;
        acc_next          = acc_reg;
        ovf_next          = ovf_reg;
        start_line_next   = start_line_reg;
        first_col_next    = first_col_reg;
        cur_line_next     = cur_line_reg;
        cur_col_next      = cur_col_reg;
        wbank_next        = wbank_reg;
        busy_next         = busy_reg;
        extra_valid_next  = extra_valid_reg;
        extra_next        = extra_reg;
        q_push            = 1'b0;
        q_data            = own_cmd;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = fold_char;
        do_flush          = 1'b0;
        prod              = '0;

        // string readout finished, its bank is free again
        if (back_st.done) begin
            busy_next[back_st.bank] = 1'b0;
        end

        // second command of the previous item
        if (extra_valid_reg && !q_full) begin
            q_push           = 1'b1;
            q_data           = extra_reg;
            extra_valid_next = 1'b0;
        end

        if (accept) begin
            if (s_data.action == ACT_END) begin
                do_flush      = (pending_kind_reg != PK_NONE);
                cur_line_next = POS_W'(1);
                cur_col_next  = POS_W'(1);
            end else if (byte_val <= CH_ASCII_MAX) begin
                do_flush = (pending_kind_reg != PK_NONE) &&
                           (is_space || is_punct ||
                            ((pending_kind_reg == PK_STRING) && is_digit) ||
                            ((pending_kind_reg == PK_NUMBER) && is_alpha));
            end

            // issue commands, flushed token first
            if (do_flush) begin
                q_push = 1'b1;
                q_data = flush_cmd;
                if ((s_data.action == ACT_BYTE) && own_valid) begin
                    extra_valid_next = 1'b1;
                    extra_next       = own_cmd;
                end
                if (pending_kind_reg == PK_STRING) begin
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                end
                pending_kind_next = PK_NONE;
                len_next          = '0;
                acc_next          = '0;
                ovf_next          = 1'b0;
            end else if ((s_data.action == ACT_BYTE) && (byte_val <= CH_ASCII_MAX) &&
                         (is_space || is_punct) && own_valid) begin
                q_push = 1'b1;
                q_data = own_cmd;
            end

            if ((s_data.action == ACT_BYTE) && (byte_val <= CH_ASCII_MAX)) begin
                // digits accumulate with saturation
                if (is_digit && !cfg.drop_numbers) begin
                    if (pending_kind_next != PK_NUMBER) begin
                        pending_kind_next = PK_NUMBER;
                        start_line_next   = cur_line_reg;
                        first_col_next    = cur_col_reg;
                        len_next          = '0;
                        acc_next          = '0;
                        ovf_next          = 1'b0;
                    end
                    prod = (PROD_W'(acc_next) << 3) + (PROD_W'(acc_next) << 1) +
                           PROD_W'(byte_val[3:0]);
                    if (prod > PROD_W'(NUM_MAX)) begin
                        acc_next = NUM_MAX;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = prod[NUM_W-1:0];
                    end
                end

                // letters go into the current bank
                if (is_alpha) begin
                    if (pending_kind_next != PK_STRING) begin
                        pending_kind_next = PK_STRING;
                        start_line_next   = cur_line_reg;
                        first_col_next    = cur_col_reg;
                        len_next          = '0;
                        acc_next          = '0;
                        ovf_next          = 1'b0;
                    end
                    if (len_next < LEN_W'(MAX_TOKEN_CHARS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = {wbank_next, len_next[IDX_W-1:0]};
                        len_next  = len_next + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end

                // position counters
                if (byte_val == CH_NEWLINE) begin
                    if (cur_line_reg < POS_MAX) begin
                        cur_line_next = cur_line_reg + 1'b1;
                    end
                    cur_col_next = POS_W'(1);
                end else if (cur_col_reg < POS_MAX) begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_kind_reg <= PK_NONE;
            len_reg          <= '0;
            acc_reg          <= '0;
            ovf_reg          <= 1'b0;
            start_line_reg   <= POS_W'(1);
            first_col_reg    <= POS_W'(1);
            cur_line_reg     <= POS_W'(1);
            cur_col_reg      <= POS_W'(1);
            wbank_reg        <= 1'b0;
            busy_reg         <= '0;
            extra_valid_reg  <= 1'b0;
        end else begin
            pending_kind_reg <= pending_kind_next;
            len_reg          <= len_next;
            acc_reg          <= acc_next;
            ovf_reg          <= ovf_next;
            start_line_reg   <= start_line_next;
            first_col_reg    <= first_col_next;
            cur_line_reg     <= cur_line_next;
            cur_col_reg      <= cur_col_next;
            wbank_reg        <= wbank_next;
            busy_reg         <= busy_next;
            extra_valid_reg  <= extra_valid_next;
        end
    end

    // second command payload
    always_ff @(posedge aclk) begin
        extra_reg <= extra_next;
    end

endmodule

`default_nettype wire

// ===== sv/pbt_back.sv =====
// back end: turns queued commands into result transfers
`timescale 1ns / 1ps
`default_nettype none

module pbt_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  pbt_pkg::cmd_t                q_data,
    output logic                         ram_re,
    output logic [pbt_pkg::RAM_AW-1:0]   ram_raddr,
    input  logic [pbt_pkg::CHAR_W-1:0]   ram_rdata,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pbt_pkg::out_item_t           m_data,
    output pbt_pkg::back_status_t        back_st
);
    import pbt_pkg::*;

    localparam logic [1:0] B_IDLE   = 2'd0;
    localparam logic [1:0] B_SINGLE = 2'd1;
    localparam logic [1:0] B_READ   = 2'd2;
    localparam logic [1:0] B_EMIT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    cmd_t             cur_reg, cur_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             out_free;
    logic             is_last;

    assign out_free  = !out_valid_reg || m_ready;
    assign is_last   = ((idx_reg + 1'b1) == cur_reg.length);
    assign ram_raddr = {cur_reg.bank, idx_reg[IDX_W-1:0]};
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        back_st        = '0;
        back_st.bank   = cur_reg.bank;

        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cur_next   = q_data;
                    idx_next   = '0;
                    state_next = (q_data.kind == TK_STRING) ? B_READ : B_SINGLE;
                end
            end
            B_SINGLE: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_next.token_kind    = cur_reg.kind;
                    out_next.line_number   = cur_reg.line;
                    out_next.column_number = cur_reg.column;
                    out_next.number_value  = cur_reg.number;
                    out_next.char_code     = cur_reg.char_code;
                    out_next.last_of_token = 1'b1;
                    out_next.overflow_flag = cur_reg.ovf;
                    state_next             = B_IDLE;
                end
            end
            B_READ: begin
                ram_re     = 1'b1;
                state_next = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_next.token_kind    = TK_STRING;
                    out_next.line_number   = cur_reg.line;
                    out_next.column_number = cur_reg.column;
                    out_next.number_value  = '0;
                    out_next.char_code     = ram_rdata;
                    out_next.last_of_token = is_last;
                    out_next.overflow_flag = cur_reg.ovf;
                    if (is_last) begin
                        back_st.done = 1'b1;
                        state_next   = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== sv/plaintext_byte_tokenizer_top.sv =====
// top level of the plaintext byte tokenizer with its register port
//
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  in_item_t  (action, text_byte)
// m_        out        m_valid / m_ready  out_item_t (one token character or token)
// apb       in         psel / penable     four option bits at 0x0, 0x4, 0x8, 0xc
//
// most bytes push at most one command; a byte that ends a token and also makes a
// punctuation or newline token pushes two, the second from a spare register
// string tokens leave one character at a time, each read from the buffer ram
// before it is emitted; number, punctuation and newline tokens need no ram read
// input stalls while that second command waits, when the command queue is full, or
// when a new string would need the buffer bank whose string is still being read out
// synchronous active-low reset; no clearing pass, the buffer is never read unwritten
`timescale 1ns / 1ps
`default_nettype none

module plaintext_byte_tokenizer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pbt_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pbt_pkg::out_item_t           m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pbt_pkg::*;

`include "plaintext_byte_tokenizer_top_assert.svh"

    cfg_t             cfg_reg, cfg_next;
    logic             cfg_write;
    logic [1:0]       reg_index;
    logic             q_full, q_push, q_pop, q_empty;
    cmd_t             q_in, q_out;
    logic             ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [CHAR_W-1:0] ram_wdata, ram_rdata;
    back_status_t     back_st;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_index)
                REG_DROP_PUNCT: cfg_next.drop_punctuation = pwdata[0];
                REG_FOLD_LOWER: cfg_next.fold_lowercase   = pwdata[0];
                REG_DROP_NUM:   cfg_next.drop_numbers     = pwdata[0];
                REG_DROP_NL:    cfg_next.drop_newlines    = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_DROP_PUNCT: prdata = {31'b0, cfg_reg.drop_punctuation};
            REG_FOLD_LOWER: prdata = {31'b0, cfg_reg.fold_lowercase};
            REG_DROP_NUM:   prdata = {31'b0, cfg_reg.drop_numbers};
            REG_DROP_NL:    prdata = {31'b0, cfg_reg.drop_newlines};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    pbt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .back_st   (back_st)
    );

    // command queue
    pbt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // two-bank string buffer
    pbt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RAM_DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back end
    pbt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .back_st   (back_st)
    );

    // result consistency checks
    `PBT_ASSERT_IMPLIES(a_single_is_last, aclk, aresetn, m_valid && (m_data.token_kind != TK_STRING), m_data.last_of_token)
    `PBT_ASSERT_IMPLIES(a_punct_no_flag, aclk, aresetn, m_valid && ((m_data.token_kind == TK_PUNCT) || (m_data.token_kind == TK_NEWLINE)), !m_data.overflow_flag)
    `PBT_ASSERT_NEVER(a_number_no_char, aclk, aresetn, m_valid && (m_data.token_kind == TK_NUMBER) && (m_data.char_code != '0))
    `PBT_ASSERT_NEVER(a_value_only_number, aclk, aresetn, m_valid && (m_data.token_kind != TK_NUMBER) && (m_data.number_value != '0))

endmodule

`default_nettype wire
